/* rtl/quaternion_multiply_rotate_macros.svh */
// Assertion helpers; clocked on clk_i, disabled while rst_ni is low.
`ifndef QUATERNION_MULTIPLY_ROTATE_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_MACROS_SVH
`ifndef SYNTHESIS
`define QMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QMR_ASSERT(lbl, prop, msg)
`define QMR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/qmr_pkg.sv */
`default_nettype none
package qmr_pkg;
  typedef enum logic {
    KIND_MUL = 1'b0,
    KIND_ROT = 1'b1
  } kind_e;

  typedef struct packed {
    logic valid;
    logic rot;
  } ctl_t;
endpackage
`default_nettype wire

/* rtl/quaternion_multiply_rotate.sv */
`default_nettype none
// Fixed-point quaternion unit, signed words of WORD_BITS bits with FRACTION_BITS fraction
// bits. kind 0 returns the Hamilton product a*b; kind 1 rotates vector b by a as
// a*(b,0)*conj(a) with r_w zero. Each partial product is floored by the fraction bits,
// sums saturate and set saturated. One item is accepted per cycle while full_o is low;
// an item passes through a two-entry input queue, two Hamilton units of two stages
// each (16 multipliers and an add/saturate stage), and a two-entry result queue.
module quaternion_multiply_rotate #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 kind_i,
  input  logic [WORD_BITS-1:0] a_x_i,
  input  logic [WORD_BITS-1:0] a_y_i,
  input  logic [WORD_BITS-1:0] a_z_i,
  input  logic [WORD_BITS-1:0] a_w_i,
  input  logic [WORD_BITS-1:0] b_x_i,
  input  logic [WORD_BITS-1:0] b_y_i,
  input  logic [WORD_BITS-1:0] b_z_i,
  input  logic [WORD_BITS-1:0] b_w_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [WORD_BITS-1:0] r_x_o,
  output logic [WORD_BITS-1:0] r_y_o,
  output logic [WORD_BITS-1:0] r_z_o,
  output logic [WORD_BITS-1:0] r_w_o,
  output logic                 saturated_o
);
  localparam int W      = WORD_BITS;
  localparam int ITEM_W = 1 + 12 * W + 8;
  localparam int RES_W  = 4 * W + 1;

  logic              f_push, mid_full, mid_empty, mid_pop, out_push, out_full;
  logic [ITEM_W-1:0] f_item, mid_data;
  logic [RES_W-1:0]  res_in, res_out;

  qmr_front #(.WORD_BITS(W), .ITEM_W(ITEM_W)) u_front (
    .push_i, .kind_i, .a_x_i, .a_y_i, .a_z_i, .a_w_i,
    .b_x_i, .b_y_i, .b_z_i, .b_w_i,
    .full_i(mid_full), .push_o(f_push), .item_o(f_item)
  );

  qmr_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_mid_q (
    .clk_i, .rst_ni, .push_i(f_push), .data_i(f_item), .full_o(mid_full),
    .pop_i(mid_pop), .data_o(mid_data), .empty_o(mid_empty)
  );

  qmr_back #(
    .WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS), .ITEM_W(ITEM_W), .RES_W(RES_W)
  ) u_back (
    .clk_i, .rst_ni, .mid_empty_i(mid_empty), .mid_data_i(mid_data),
    .mid_pop_o(mid_pop), .out_full_i(out_full), .out_push_o(out_push),
    .out_data_o(res_in)
  );

  qmr_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_out_q (
    .clk_i, .rst_ni, .push_i(out_push), .data_i(res_in), .full_o(out_full),
    .pop_i, .data_o(res_out), .empty_o
  );

  assign full_o      = mid_full;
  assign r_x_o       = res_out[RES_W-1 -: W];
  assign r_y_o       = res_out[RES_W-1-W -: W];
  assign r_z_o       = res_out[RES_W-1-2*W -: W];
  assign r_w_o       = res_out[W:1];
  assign saturated_o = res_out[0];
endmodule
`default_nettype wire

/* rtl/qmr_fifo.sv */
`default_nettype none
module qmr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

/* rtl/qmr_front.sv */
`default_nettype none
module qmr_front #(
  parameter int WORD_BITS = 32,
  parameter int ITEM_W    = 1 + 12 * WORD_BITS + 8
) (
  input  logic                 push_i,
  input  logic                 kind_i,
  input  logic [WORD_BITS-1:0] a_x_i,
  input  logic [WORD_BITS-1:0] a_y_i,
  input  logic [WORD_BITS-1:0] a_z_i,
  input  logic [WORD_BITS-1:0] a_w_i,
  input  logic [WORD_BITS-1:0] b_x_i,
  input  logic [WORD_BITS-1:0] b_y_i,
  input  logic [WORD_BITS-1:0] b_z_i,
  input  logic [WORD_BITS-1:0] b_w_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [ITEM_W-1:0]    item_o
);
  import qmr_pkg::*;
  localparam int W  = WORD_BITS;
  localparam int XW = W + 1;

  kind_e         kind;
  logic [XW-1:0] q_x, q_y, q_z, q_w, c_x, c_y, c_z, c_w;

  assign kind = kind_e'(kind_i);
  assign q_x  = {b_x_i[W-1], b_x_i};
  assign q_y  = {b_y_i[W-1], b_y_i};
  assign q_z  = {b_z_i[W-1], b_z_i};
  // vector rotation uses (b, 0)
  assign q_w  = (kind == KIND_ROT) ? '0 : {b_w_i[W-1], b_w_i};
  // conjugate of a, negation kept one bit wider
  assign c_x  = '0 - {a_x_i[W-1], a_x_i};
  assign c_y  = '0 - {a_y_i[W-1], a_y_i};
  assign c_z  = '0 - {a_z_i[W-1], a_z_i};
  assign c_w  = {a_w_i[W-1], a_w_i};

  assign push_o = push_i && !full_i;
  assign item_o = {kind == KIND_ROT, a_x_i, a_y_i, a_z_i, a_w_i,
                   q_x, q_y, q_z, q_w, c_x, c_y, c_z, c_w};
endmodule
`default_nettype wire

/* rtl/qmr_ham.sv */
`default_nettype none
module qmr_ham #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16,
  parameter int SIDE_W        = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  qmr_pkg::ctl_t               ctl_i,
  input  logic signed [WORD_BITS-1:0] p_i [4],
  input  logic signed [WORD_BITS:0]   q_i [4],
  input  logic [SIDE_W-1:0]           side_i,
  output qmr_pkg::ctl_t               ctl_o,
  output logic signed [WORD_BITS-1:0] r_o [4],
  output logic [3:0]                  clip_o,
  output logic [SIDE_W-1:0]           side_o
);
  import qmr_pkg::*;
  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W + 1;
  localparam int SW = PW + 2;

  ctl_t                 ctl1_q, ctl2_q;
  logic [SIDE_W-1:0]    side1_q, side2_q;
  logic signed [PW-1:0] prod_d [16];
  logic signed [PW-1:0] prod_q [16];
  logic signed [SW-1:0] t [16];
  logic signed [SW-1:0] s [4];
  logic signed [W-1:0]  r_d [4];
  logic [3:0]           clip_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[i*4+j] = PW'(p_i[i] * q_i[j]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      t[k] = SW'(prod_q[k] >>> FRACTION_BITS);
    end
    s[0] = t[1*4+2] - t[2*4+1] + t[0*4+3] + t[3*4+0];
    s[1] = t[2*4+0] - t[0*4+2] + t[1*4+3] + t[3*4+1];
    s[2] = t[0*4+1] - t[1*4+0] + t[2*4+3] + t[3*4+2];
    s[3] = t[3*4+3] - t[0*4+0] - t[1*4+1] - t[2*4+2];
    for (int k = 0; k < 4; k++) begin
      clip_d[k] = !((&s[k][SW-1:W-1]) || !(|s[k][SW-1:W-1]));
      if (!clip_d[k]) begin
        r_d[k] = s[k][W-1:0];
      end else if (s[k][SW-1]) begin
        r_d[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        r_d[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      side1_q <= side_i;
      r_o     <= r_d;
      clip_o  <= clip_d;
      side2_q <= side1_q;
    end
  end

  assign ctl_o  = ctl2_q;
  assign side_o = side2_q;
endmodule
`default_nettype wire

/* rtl/qmr_back.sv */
`default_nettype none
`include "quaternion_multiply_rotate_macros.svh"
module qmr_back #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16,
  parameter int ITEM_W        = 1 + 12 * WORD_BITS + 8,
  parameter int RES_W         = 4 * WORD_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mid_empty_i,
  input  logic [ITEM_W-1:0] mid_data_i,
  output logic              mid_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output logic [RES_W-1:0]  out_data_o
);
  import qmr_pkg::*;
  localparam int W  = WORD_BITS;
  localparam int XW = W + 1;
  localparam int CS = 4 * XW;
  localparam int S2 = 4 * W + 1;

  logic                en;
  ctl_t                ctl0, ctl1, ctl2;
  logic signed [W-1:0]  a [4];
  logic signed [XW-1:0] q [4];
  logic signed [XW-1:0] c [4];
  logic [CS-1:0]        c_side, c_side1;
  logic signed [W-1:0]  r1 [4];
  logic signed [W-1:0]  r2 [4];
  logic signed [W-1:0]  r1_held [4];
  logic [3:0]           clip1, clip2;
  logic [S2-1:0]        side2_in, side2_out;
  logic                 sat1_held;
  logic [W-1:0]         w_fin;
  logic                 sat_fin;

  assign en        = !(ctl2.valid && out_full_i);
  assign mid_pop_o = en && !mid_empty_i;
  assign ctl0      = '{valid: !mid_empty_i, rot: mid_data_i[ITEM_W-1]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a[k] = mid_data_i[ITEM_W-2-k*W -: W];
      q[k] = mid_data_i[2*CS-1-k*XW -: XW];
    end
  end
  assign c_side = mid_data_i[CS-1:0];

  qmr_ham #(
    .WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS), .SIDE_W(CS)
  ) u_ham1 (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl0), .p_i(a), .q_i(q),
    .side_i(c_side), .ctl_o(ctl1), .r_o(r1), .clip_o(clip1), .side_o(c_side1)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c[k] = c_side1[CS-1-k*XW -: XW];
    end
  end
  assign side2_in = {r1[0], r1[1], r1[2], r1[3], |clip1};

  qmr_ham #(
    .WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS), .SIDE_W(S2)
  ) u_ham2 (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctl1), .p_i(r1), .q_i(c),
    .side_i(side2_in), .ctl_o(ctl2), .r_o(r2), .clip_o(clip2), .side_o(side2_out)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r1_held[k] = side2_out[S2-1-k*W -: W];
    end
  end
  assign sat1_held = side2_out[0];

  assign w_fin   = ctl2.rot ? '0 : r1_held[3];
  assign sat_fin = ctl2.rot ? (sat1_held || (|clip2[2:0])) : sat1_held;

  assign out_push_o = ctl2.valid && !out_full_i;
  assign out_data_o = ctl2.rot ? {r2[0], r2[1], r2[2], w_fin, sat_fin}
                               : {r1_held[0], r1_held[1], r1_held[2], w_fin, sat_fin};

  `QMR_ASSERT_NEXT(stall_hold_a, ctl2.valid && out_full_i, ctl2.valid, "stalled result lost")
  `QMR_ASSERT(rot_w_zero_a, out_push_o && ctl2.rot |-> w_fin == '0, "rotation w not zero")
  `QMR_ASSERT(pop_stall_a, mid_pop_o |-> !(ctl2.valid && out_full_i), "issue during stall")
endmodule
`default_nettype wire
